[design/qmm_pkg.sv]
// qmm_pkg: shared types, fixed-point constants and pipeline stage map for the
// quad motor mixer with battery compensation.
// No dependencies.
package qmm_pkg;

  // field widths
  localparam int unsigned NUM_MOTORS = 4;
  localparam int unsigned CMD_W      = 16;
  localparam int unsigned DUTY_W     = 8;

  // upper bound on any motor duty
  localparam logic [DUTY_W-1:0] DUTY_CAP = 8'd254;

  // t = m*75/255 = (5*m)/17 in Q16.16; x/17 by reciprocal 2^24/17
  localparam logic [19:0] RECIP_17    = 20'd986895;
  localparam int unsigned RECIP_SHIFT = 24;
  // floor(b*2^16/17) equals b*3855 for every remainder b of 0..16
  localparam logic [15:0] FRAC_17     = 16'd3855;

  // motor model coefficients in Q0.24
  localparam logic [13:0] COEF_A = 14'd10467;    // 0.0006239
  localparam logic [20:0] COEF_B = 21'd1476395;  // 0.088

  // 255 duty steps times 1000 mV per volt
  localparam logic [17:0] MV_SCALE = 18'd255000;

  // duty quotient: one bit per divide stage
  localparam int unsigned DIV_STEPS = DUTY_W;
  localparam int unsigned REM_W     = CMD_W + DIV_STEPS;

  // stage map: 0 mix, 1..7 model arithmetic, 8..15 divide, 16 output
  localparam int unsigned STG_DIV = 8;
  localparam int unsigned STG_OUT = STG_DIV + DIV_STEPS;
  localparam int unsigned NUM_STG = STG_OUT + 1;

  typedef logic [CMD_W-1:0]              msum_t;
  typedef msum_t [NUM_MOTORS-1:0]        msum_vec_t;
  typedef logic [DUTY_W-1:0]             duty_t;

endpackage

[design/qmm_mix.sv]
// qmm_mix: X-frame mixing of thrust, roll, pitch and yaw into four saturated
// motor sums. Uses qmm_pkg.
module qmm_mix import qmm_pkg::*; (
  input  logic [CMD_W-1:0]        thrust_i,
  input  logic signed [CMD_W-1:0] roll_i,
  input  logic signed [CMD_W-1:0] pitch_i,
  input  logic signed [CMD_W-1:0] yaw_i,
  output msum_vec_t               sum_o
);

  logic signed [CMD_W:0]   roll_h;
  logic signed [CMD_W:0]   pitch_h;
  logic signed [CMD_W+2:0] t_s;
  logic signed [CMD_W+2:0] r_s;
  logic signed [CMD_W+2:0] p_s;
  logic signed [CMD_W+2:0] y_s;
  logic signed [CMD_W+2:0] raw [NUM_MOTORS];

  // halve roll and pitch, rounding toward zero
  assign roll_h  = ($signed({roll_i[CMD_W-1], roll_i})
                   + $signed({{CMD_W{1'b0}}, roll_i[CMD_W-1]})) >>> 1;
  assign pitch_h = ($signed({pitch_i[CMD_W-1], pitch_i})
                   + $signed({{CMD_W{1'b0}}, pitch_i[CMD_W-1]})) >>> 1;

  // sign-extend to a width that holds every sum
  assign t_s = $signed({3'b000, thrust_i});
  assign r_s = $signed({{2{roll_h[CMD_W]}}, roll_h});
  assign p_s = $signed({{2{pitch_h[CMD_W]}}, pitch_h});
  assign y_s = $signed({{3{yaw_i[CMD_W-1]}}, yaw_i});

  // X-frame sums
  assign raw[0] = t_s + r_s + p_s + y_s;
  assign raw[1] = t_s + r_s - p_s - y_s;
  assign raw[2] = t_s - r_s - p_s + y_s;
  assign raw[3] = t_s - r_s + p_s - y_s;

  // saturate to 0..65535, all motors off with zero thrust
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (thrust_i == '0 || raw[i][CMD_W+2]) begin
        sum_o[i] = '0;
      end else if (raw[i][CMD_W+1:CMD_W] != 2'b00) begin
        sum_o[i] = '1;
      end else begin
        sum_o[i] = raw[i][CMD_W-1:0];
      end
    end
  end

endmodule

[design/qmm_div_step.sv]
// qmm_div_step: one restoring division step, yields one quotient bit.
// Uses qmm_pkg.
module qmm_div_step import qmm_pkg::*; (
  input  logic [REM_W-1:0] rem_i,
  input  logic [REM_W-1:0] dvs_i,
  output logic [REM_W-1:0] rem_o,
  output logic             bit_o
);

  // subtract the shifted divisor when it fits
  assign bit_o = (rem_i >= dvs_i);
  assign rem_o = bit_o ? (rem_i - dvs_i) : rem_i;

endmodule

[design/qmm_lane.sv]
// qmm_lane: battery compensation pipeline for one motor, stages 1 to 16.
// Uses qmm_pkg and qmm_div_step.
module qmm_lane import qmm_pkg::*; (
  input  logic               clk_i,
  input  logic [STG_OUT:1]   en_i,
  input  msum_t              sum_i,
  input  logic [CMD_W-1:0]   vb_i,
  output duty_t              duty_o
);

  // battery voltage travels beside the data
  logic [CMD_W-1:0] vb_q [1:STG_OUT-2];

  // stage 1: x = 5*m and estimate of x/17
  logic [18:0] x_d;
  logic [38:0] xr_prod;
  logic [18:0] x_q;
  logic [14:0] aest_q;

  // stage 2: exact quotient and remainder, t in Q16.16
  logic [18:0] a17;
  logic [18:0] rem17;
  logic [5:0]  rem_lo;
  logic        fix;
  logic [14:0] a_fix;
  logic [4:0]  b_fix;
  logic [30:0] tq_d;
  logic [30:0] tq_q;

  // stage 3: t*t and B*t
  logic [61:0] sq;
  logic [51:0] pos_d;
  logic [45:0] tt_q;
  logic [51:0] pos3_q;

  // stage 4: A*t*t
  logic [59:0] neg_d;
  logic [59:0] neg_q;
  logic [51:0] pos4_q;

  // stage 5: model voltage, negative clamps to zero
  logic [51:0] volt_d;
  logic [51:0] volt_q;

  // stage 6: partial products of 255000*volt
  logic [43:0] ph_d;
  logic [43:0] pl_d;
  logic [43:0] ph_q;
  logic [43:0] pl_q;

  // stage 7: numerator above 2^40 and saturation check
  logic [69:0] num;
  logic [29:0] num_hi;
  logic        sat_d;

  // stages 8..15: duty quotient, one bit per stage
  logic [REM_W-1:0]  rem_q [DIV_STEPS+1];
  logic [DUTY_W-1:0] quo_q [DIV_STEPS+1];
  logic              sat_q [DIV_STEPS+1];
  logic [REM_W-1:0]  rem_nx [DIV_STEPS];
  logic              bit_nx [DIV_STEPS];
  logic [REM_W-1:0]  dvs [DIV_STEPS];

  // stage 16: limit and cap
  duty_t duty_d;
  duty_t duty_q;

  // battery voltage delay line
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vb_q[1] <= vb_i;
    end
    for (int k = 2; k <= STG_OUT - 2; k++) begin
      if (en_i[k]) begin
        vb_q[k] <= vb_q[k-1];
      end
    end
  end

  // stage 1
  assign x_d     = {1'b0, sum_i, 2'b00} + {3'b000, sum_i};
  assign xr_prod = {20'd0, x_d} * {19'd0, RECIP_17};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q    <= x_d;
      aest_q <= xr_prod[RECIP_SHIFT+14:RECIP_SHIFT];
    end
  end

  // stage 2: estimate is low by at most one
  assign a17    = {aest_q, 4'b0000} + {4'b0000, aest_q};
  assign rem17  = x_q - a17;
  assign rem_lo = rem17[5:0];
  assign fix    = (rem_lo >= 6'd17);
  assign a_fix  = aest_q + {14'd0, fix};
  assign b_fix  = fix ? 5'(rem_lo - 6'd17) : rem_lo[4:0];
  assign tq_d   = {a_fix, 16'({11'd0, b_fix} * FRAC_17)};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      tq_q <= tq_d;
    end
  end

  // stage 3
  assign sq    = {31'd0, tq_q} * {31'd0, tq_q};
  assign pos_d = {21'd0, tq_q} * {31'd0, COEF_B};

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      tt_q   <= sq[61:16];
      pos3_q <= pos_d;
    end
  end

  // stage 4
  assign neg_d = {46'd0, COEF_A} * {14'd0, tt_q};

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      neg_q  <= neg_d;
      pos4_q <= pos3_q;
    end
  end

  // stage 5
  assign volt_d = ({8'd0, pos4_q} > neg_q) ? (pos4_q - neg_q[51:0]) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      volt_q <= volt_d;
    end
  end

  // stage 6
  assign ph_d = {26'd0, MV_SCALE} * {18'd0, volt_q[51:26]};
  assign pl_d = {26'd0, MV_SCALE} * {18'd0, volt_q[25:0]};

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
  end

  // stage 7: low 40 bits never reach the quotient; zero battery saturates
  assign num    = {ph_q, 26'd0} + {26'd0, pl_q};
  assign num_hi = num[69:40];
  assign sat_d  = (num_hi >= {6'd0, vb_q[6], {DIV_STEPS{1'b0}}});

  // divide steps, most significant quotient bit first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned SH = DIV_STEPS - 1 - j;

    assign dvs[j] = {{DIV_STEPS{1'b0}}, vb_q[STG_DIV+j-1]} << SH;

    qmm_div_step u_step (
      .rem_i (rem_q[j]),
      .dvs_i (dvs[j]),
      .rem_o (rem_nx[j]),
      .bit_o (bit_nx[j])
    );
  end

  // stage 7 load, then one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      rem_q[0] <= num_hi[REM_W-1:0];
      quo_q[0] <= '0;
      sat_q[0] <= sat_d;
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en_i[STG_DIV+j]) begin
        rem_q[j+1] <= rem_nx[j];
        quo_q[j+1] <= {quo_q[j][DUTY_W-2:0], bit_nx[j]};
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  // stage 16
  always_comb begin
    if (sat_q[DIV_STEPS] || quo_q[DIV_STEPS] > DUTY_CAP) begin
      duty_d = DUTY_CAP;
    end else begin
      duty_d = quo_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[STG_OUT]) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

[design/quad_motor_mixer_batt_comp_top.sv]
// quad_motor_mixer_batt_comp_top: mixer stage, handshake control and four
// compensation lanes. Uses qmm_pkg, qmm_mix and qmm_lane.
//
// Takes one control set (thrust, roll, pitch, yaw, battery millivolts) per
// clock while the input is not stalled and returns four motor duties in
// 0..254, one result per transfer, in order. The pipeline is 17 stages deep:
// a mix stage, seven stages of fixed-point motor model (divide by 17,
// squaring, coefficient products, scaling by 255000), eight restoring divide
// stages that produce the duty one bit per stage against the battery voltage,
// and the output register. With no stall an input transfer passes through
// every stage register in turn before the output valid rises; throughput is
// one item per cycle while the output is not stalled. A stall at the output
// holds only the stages that are full; empty stages keep filling, so input
// is taken as long as any stage has room. No state carries over between items.
module quad_motor_mixer_batt_comp_top import qmm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        thrust_cmd_i,
  input  logic signed [CMD_W-1:0] roll_cmd_i,
  input  logic signed [CMD_W-1:0] pitch_cmd_i,
  input  logic signed [CMD_W-1:0] yaw_cmd_i,
  input  logic [CMD_W-1:0]        battery_millivolts_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output duty_t                   motor_one_duty_o,
  output duty_t                   motor_two_duty_o,
  output duty_t                   motor_three_duty_o,
  output duty_t                   motor_four_duty_o
);

  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] vld_d;
  logic [NUM_STG:0]   rdy;
  msum_vec_t          sum_d;
  msum_vec_t          sum_q;
  logic [CMD_W-1:0]   vb_q;
  duty_t              duty [NUM_MOTORS];

  // a stage takes new data when it is empty or its successor moves
  assign rdy[NUM_STG] = !out_stall_i;
  for (genvar k = 0; k < NUM_STG; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  // valid bits follow the data
  assign vld_d = {vld_q[NUM_STG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[STG_OUT];

  // stage 0: mixing
  qmm_mix u_mix (
    .thrust_i (thrust_cmd_i),
    .roll_i   (roll_cmd_i),
    .pitch_i  (pitch_cmd_i),
    .yaw_i    (yaw_cmd_i),
    .sum_o    (sum_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sum_q <= sum_d;
      vb_q  <= battery_millivolts_i;
    end
  end

  // one compensation lane per motor
  for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
    qmm_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (rdy[STG_OUT:1]),
      .sum_i  (sum_q[i]),
      .vb_i   (vb_q),
      .duty_o (duty[i])
    );
  end

  assign motor_one_duty_o   = duty[0];
  assign motor_two_duty_o   = duty[1];
  assign motor_three_duty_o = duty[2];
  assign motor_four_duty_o  = duty[3];

`ifndef ASSERT_OFF
  // an empty output stage means the whole pipe can move
  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

  // duties never exceed the cap
  a_duty_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_one_duty_o <= DUTY_CAP && motor_two_duty_o <= DUTY_CAP &&
                     motor_three_duty_o <= DUTY_CAP && motor_four_duty_o <= DUTY_CAP))
    else $error("motor duty above cap");

  // an input transfer always lands in the mix stage
  a_input_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted input lost at mix stage");
`endif

endmodule
